// File: design/rlbd_pkg.sv
// Shared types and constants for the run-length byte decoder.
package rlbd_pkg;

   localparam int unsigned FRAME_SIZE_W            = 17;
   localparam int unsigned MAX_FRAME_BYTES_DEFAULT = 65536;
   localparam int unsigned BYTE_W                  = 8;
   localparam int unsigned COUNT_MASK              = 127;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_OVERFLOW = 2'd1;
   localparam logic [1:0] STATUS_TRUNC    = 2'd2;
   localparam logic [1:0] STATUS_MISMATCH = 2'd3;

   typedef struct packed {
      logic [BYTE_W-1:0] in_byte;
      logic              last_byte;
   } req_word_type;

   typedef struct packed {
      logic [BYTE_W-1:0] value;
      logic [BYTE_W-1:0] repeat_res;
      logic              done_res;
      logic [1:0]        status;
   } rsp_word_type;

endpackage

// File: design/run_length_byte_decoder.sv
// Run-length byte decoder: top level with decode state, result register and skid stage.
//
// Usage:
//   req channel carries one compressed byte a word, with a last-byte flag.
//   rsp channel carries at most one decoded word per input byte: a value with a
//   repeat count (1..128 for data, 0 for none), and done/status on the last byte.
//   csr_write_enable/csr_write_data load the expected frame size in bytes.
// Timing:
//   One input byte is taken every clock while req_stall is low. The decode of a
//   byte is done between the req handshake and the result register (or the skid
//   register while rsp is stalled). Command bytes that are not last give no word.
// Stalling:
//   A two-deep output stage (result register plus skid register) takes one more
//   result while rsp is stalled; req_stall rises only while the skid is full.
// Reset:
//   Synchronous reset clears the decode state, the frame size and both output
//   stages; the first byte after reset is read as a command byte. After each
//   last byte the decode state clears again for the next stream.
module run_length_byte_decoder
   import rlbd_pkg::*;
#(
   parameter int unsigned MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  req_word_type            req_word,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output rsp_word_type            rsp_word,
   input  logic                    csr_write_enable,
   input  logic [FRAME_SIZE_W-1:0] csr_write_data
);

   localparam int unsigned CNT_W  = $clog2(MAX_FRAME_BYTES + 1);
   localparam int unsigned WIDE_W = (CNT_W > FRAME_SIZE_W) ? CNT_W : FRAME_SIZE_W;
   localparam int unsigned SUM_W  = ((CNT_W > BYTE_W) ? CNT_W : BYTE_W) + 1;

   typedef enum logic [1:0] {
      PH_CMD,
      PH_RUN,
      PH_LIT
   } phase_type;

   logic [FRAME_SIZE_W-1:0] frame_size_ff;
   phase_type               phase_ff, phase_in;
   logic [BYTE_W-1:0]       literal_left_ff, literal_left_in;
   logic [BYTE_W-1:0]       run_length_ff, run_length_in;
   logic [CNT_W-1:0]        bytes_out_ff, bytes_out_in;
   logic                    error_ff, error_in;

   logic                    out_valid_ff;
   rsp_word_type            out_word_ff;
   logic                    skid_valid_ff;
   rsp_word_type            skid_word_ff;

   logic                    accept;
   logic [WIDE_W-1:0]       fs_wide;
   logic [WIDE_W-1:0]       max_wide;
   logic [CNT_W-1:0]        limit;
   logic [BYTE_W-1:0]       count;
   logic [SUM_W-1:0]        total;
   logic [BYTE_W-1:0]       data_val;
   logic [BYTE_W-1:0]       data_rep;
   logic                    res_valid;
   rsp_word_type            res_word;
   logic                    out_free;

   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = out_valid_ff;
   assign rsp_word  = out_word_ff;
   assign out_free  = !out_valid_ff || !rsp_stall;

   // limit = frame size capped at the largest frame
   assign fs_wide  = WIDE_W'(frame_size_ff);
   assign max_wide = WIDE_W'(MAX_FRAME_BYTES);
   assign limit    = (fs_wide > max_wide) ? CNT_W'(max_wide) : CNT_W'(fs_wide);

   assign count = (req_word.in_byte & BYTE_W'(COUNT_MASK)) + BYTE_W'(1);
   assign total = SUM_W'(bytes_out_ff) + SUM_W'(count);

   always_comb begin
      phase_in        = phase_ff;
      literal_left_in = literal_left_ff;
      run_length_in   = run_length_ff;
      bytes_out_in    = bytes_out_ff;
      error_in        = error_ff;
      data_val        = '0;
      data_rep        = '0;
      if (!error_ff) begin
         case (phase_ff)
            PH_RUN: begin
               data_val      = req_word.in_byte;
               data_rep      = run_length_ff;
               bytes_out_in  = bytes_out_ff + CNT_W'(run_length_ff);
               run_length_in = '0;
               phase_in      = PH_CMD;
            end
            PH_LIT: begin
               data_val     = req_word.in_byte;
               data_rep     = BYTE_W'(1);
               bytes_out_in = bytes_out_ff + CNT_W'(1);
               if (literal_left_ff != '0) begin
                  literal_left_in = literal_left_ff - BYTE_W'(1);
               end
               if (literal_left_in == '0) begin
                  phase_in = PH_CMD;
               end
            end
            default: begin
               if (total > SUM_W'(limit)) begin
                  error_in = 1'b1;
                  phase_in = PH_CMD;
               end else if (req_word.in_byte[BYTE_W-1]) begin
                  run_length_in = count;
                  phase_in      = PH_RUN;
               end else begin
                  literal_left_in = count;
                  phase_in        = PH_LIT;
               end
            end
         endcase
      end

      res_word            = '0;
      res_word.value      = data_val;
      res_word.repeat_res = data_rep;
      res_word.done_res   = req_word.last_byte;
      res_valid           = accept && (req_word.last_byte || data_rep != '0);
      if (req_word.last_byte) begin
         if (error_in) begin
            res_word.status = STATUS_OVERFLOW;
         end else if (phase_in == PH_RUN || phase_in == PH_LIT) begin
            res_word.status = STATUS_TRUNC;
         end else if (bytes_out_in != limit) begin
            res_word.status = STATUS_MISMATCH;
         end else begin
            res_word.status = STATUS_OK;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_size_ff   <= '0;
         phase_ff        <= PH_CMD;
         literal_left_ff <= '0;
         run_length_ff   <= '0;
         bytes_out_ff    <= '0;
         error_ff        <= 1'b0;
         out_valid_ff    <= 1'b0;
         skid_valid_ff   <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            frame_size_ff <= csr_write_data;
         end
         if (accept) begin
            if (req_word.last_byte) begin
               phase_ff        <= PH_CMD;
               literal_left_ff <= '0;
               run_length_ff   <= '0;
               bytes_out_ff    <= '0;
               error_ff        <= 1'b0;
            end else begin
               phase_ff        <= phase_in;
               literal_left_ff <= literal_left_in;
               run_length_ff   <= run_length_in;
               bytes_out_ff    <= bytes_out_in;
               error_ff        <= error_in;
            end
         end
         // skid full means req is stalled, so no new result arrives then
         if (out_free) begin
            if (skid_valid_ff) begin
               out_valid_ff  <= 1'b1;
               out_word_ff   <= skid_word_ff;
               skid_valid_ff <= 1'b0;
            end else begin
               out_valid_ff <= res_valid;
               out_word_ff  <= res_word;
            end
         end else if (res_valid) begin
            skid_valid_ff <= 1'b1;
            skid_word_ff  <= res_word;
         end
      end
   end

endmodule

// File: verif/tb.sv
// Testbench for the run-length byte decoder: directed and random streams, checked word by word.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import rlbd_pkg::*;

   typedef enum logic [1:0] {DEC_CMD, DEC_RUN, DEC_LIT} dec_phase_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   req_word_type            req_word = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   rsp_word_type            rsp_word;
   logic                    csr_write_enable = 1'b0;
   logic [FRAME_SIZE_W-1:0] csr_write_data = '0;

   // decoder state as predicted
   dec_phase_type dec_phase = DEC_CMD;
   int unsigned   lit_left = 0;
   int unsigned   run_len = 0;
   int unsigned   bytes_out = 0;
   logic [1:0]    err_code = STATUS_OK;
   int unsigned   frame_bytes = 0;

   rsp_word_type  decoded_words[$];
   logic [7:0]    stream_bytes[$];
   int unsigned   fail_count = 0;

   bit            req_idle_on = 1'b1;
   logic          rsp_idle_on = 1'b1;
   logic          hold_start = 1'b0;
   int unsigned   hold_left = 0;
   int unsigned   burst_left = 0;
   rsp_word_type  want;

   run_length_byte_decoder u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_word         (req_word),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_word         (rsp_word),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always #2 clock = ~clock;

   // receiver: random stall bursts plus one long hold on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left <= 0;
         burst_left <= 0;
      end else if (hold_start) begin
         rsp_stall <= 1'b1;
         hold_left <= 80;
      end else if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (burst_left != 0) begin
         rsp_stall <= 1'b1;
         burst_left <= burst_left - 1;
      end else if (rsp_idle_on && $urandom_range(0, 3) == 0) begin
         rsp_stall <= 1'b1;
         burst_left <= $urandom_range(0, 9);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   task automatic flag_mismatch(input string what, input int unsigned exp_v,
                                input int unsigned got_v);
      fail_count++;
      $display("%0t mismatch %s expected %0d actual %0d", $time, what, exp_v, got_v);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (decoded_words.size() == 0) begin
            fail_count++;
            $display("%0t unexpected word expected none actual %h", $time, rsp_word);
         end else begin
            want = decoded_words.pop_front();
            if (rsp_word.value != want.value)
               flag_mismatch("value", 32'(want.value), 32'(rsp_word.value));
            if (rsp_word.repeat_res != want.repeat_res)
               flag_mismatch("repeat_res", 32'(want.repeat_res), 32'(rsp_word.repeat_res));
            if (rsp_word.done_res != want.done_res)
               flag_mismatch("done_res", 32'(want.done_res), 32'(rsp_word.done_res));
            if (rsp_word.status != want.status)
               flag_mismatch("status", 32'(want.status), 32'(rsp_word.status));
         end
      end
   end

   task automatic decode_byte(input req_word_type w);
      rsp_word_type r;
      int unsigned  lim;
      int unsigned  cnt;
      int unsigned  room;
      r = '0;
      lim = (frame_bytes > MAX_FRAME_BYTES_DEFAULT) ? MAX_FRAME_BYTES_DEFAULT : frame_bytes;
      if (err_code == STATUS_OK) begin
         case (dec_phase)
            DEC_RUN: begin
               r.value = w.in_byte;
               r.repeat_res = run_len[7:0];
               bytes_out += run_len;
               run_len = 0;
               dec_phase = DEC_CMD;
            end
            DEC_LIT: begin
               r.value = w.in_byte;
               r.repeat_res = 8'd1;
               bytes_out += 1;
               if (lit_left > 0)
                  lit_left--;
               if (lit_left == 0)
                  dec_phase = DEC_CMD;
            end
            default: begin
               cnt = (w.in_byte & COUNT_MASK) + 1;
               room = (bytes_out <= lim) ? lim - bytes_out : 0;
               if (cnt > room) begin
                  err_code = STATUS_OVERFLOW;
                  dec_phase = DEC_CMD;
               end else if (w.in_byte[7]) begin
                  run_len = cnt;
                  dec_phase = DEC_RUN;
               end else begin
                  lit_left = cnt;
                  dec_phase = DEC_LIT;
               end
            end
         endcase
      end
      if (w.last_byte) begin
         r.done_res = 1'b1;
         if (err_code != STATUS_OK)
            r.status = err_code;
         else if (dec_phase != DEC_CMD)
            r.status = STATUS_TRUNC;
         else if (bytes_out != lim)
            r.status = STATUS_MISMATCH;
         else
            r.status = STATUS_OK;
         dec_phase = DEC_CMD;
         lit_left = 0;
         run_len = 0;
         bytes_out = 0;
         err_code = STATUS_OK;
      end
      if (w.last_byte || r.repeat_res != 0)
         decoded_words.push_back(r);
   endtask

   // valid is left high after a word is taken so back-to-back words need no gap
   task automatic send_byte(input logic [7:0] b, input logic last);
      req_word_type w;
      w.in_byte = b;
      w.last_byte = last;
      if (req_idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      decode_byte(w);
   endtask

   task automatic send_stream();
      int unsigned i;
      for (i = 0; i < stream_bytes.size(); i++)
         send_byte(stream_bytes[i], i == stream_bytes.size() - 1);
      stream_bytes.delete();
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (decoded_words.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_frame(input int unsigned size);
      drain();
      csr_write_enable <= 1'b1;
      csr_write_data <= size[FRAME_SIZE_W-1:0];
      @(posedge clock);
      csr_write_enable <= 1'b0;
      frame_bytes = size;
   endtask

   // well-formed commands that decode to exactly total bytes
   task automatic build_frame(input int unsigned total);
      int unsigned left;
      int unsigned cnt;
      int unsigned cap;
      left = total;
      while (left > 0) begin
         if ($urandom_range(0, 1) == 0) begin
            cnt = $urandom_range(1, (left > 128) ? 128 : left);
            stream_bytes.push_back({1'b1, 7'(cnt - 1)});
            stream_bytes.push_back(8'($urandom_range(0, 255)));
         end else begin
            cap = ($urandom_range(0, 7) == 0) ? 128 : 6;
            cnt = $urandom_range(1, (left > cap) ? cap : left);
            stream_bytes.push_back({1'b0, 7'(cnt - 1)});
            repeat (cnt) stream_bytes.push_back(8'($urandom_range(0, 255)));
         end
         left -= cnt;
      end
   endtask

   task automatic test_decode_basics();
      set_frame(1);
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b1);
      send_byte(8'h80, 1'b0);
      send_byte(8'h00, 1'b1);
      set_frame(128);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hA5, 1'b1);
   endtask

   task automatic test_error_status();
      set_frame(0);
      send_byte(8'h00, 1'b1);
      set_frame(1);
      send_byte(8'h80, 1'b1);
      send_byte(8'h81, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h80, 1'b1);
      set_frame(4);
      send_byte(8'h02, 1'b0);
      send_byte(8'h11, 1'b0);
      send_byte(8'h22, 1'b1);
      send_byte(8'h00, 1'b0);
      send_byte(8'h5A, 1'b1);
      set_frame(65536);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b1);
   endtask

   // frame size above the cap decodes against the capped limit
   task automatic test_frame_cap();
      set_frame(131071);
      repeat (512) begin
         stream_bytes.push_back(8'hFF);
         stream_bytes.push_back(8'($urandom_range(0, 255)));
      end
      send_stream();
   endtask

   task automatic test_backpressure();
      set_frame(64);
      req_idle_on = 1'b0;
      rsp_idle_on <= 1'b0;
      hold_start <= 1'b1;
      @(posedge clock);
      hold_start <= 1'b0;
      build_frame(64);
      send_stream();
      drain();
      req_idle_on = 1'b1;
      rsp_idle_on <= 1'b1;
   endtask

   task automatic test_random_streams();
      int unsigned sent;
      int unsigned kind;
      int unsigned cut;
      int unsigned next_size;
      sent = 0;
      while (sent < 460) begin
         if (sent > 360) begin
            req_idle_on = 1'b0;
            rsp_idle_on <= 1'b0;
         end
         kind = $urandom_range(0, 9);
         if (kind == 9) begin
            repeat ($urandom_range(1, 20))
               stream_bytes.push_back(8'($urandom_range(0, 255)));
         end else begin
            build_frame(frame_bytes);
            if ((kind == 7 || kind == 8) && stream_bytes.size() > 1) begin
               cut = $urandom_range(1, stream_bytes.size() - 1);
               while (stream_bytes.size() > cut) void'(stream_bytes.pop_back());
            end else if (kind == 6) begin
               stream_bytes.push_back(8'($urandom_range(0, 255)));
               repeat ($urandom_range(0, 3))
                  stream_bytes.push_back(8'($urandom_range(0, 255)));
            end
         end
         if (stream_bytes.size() == 0)
            stream_bytes.push_back(8'($urandom_range(0, 255)));
         sent += stream_bytes.size();
         send_stream();
         if ($urandom_range(0, 2) == 0) begin
            case ($urandom_range(0, 9))
               0: next_size = 0;
               1: next_size = $urandom_range(300, 2000);
               default: next_size = $urandom_range(1, 300);
            endcase
            set_frame(next_size);
         end
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_decode_basics();
      test_error_status();
      test_frame_cap();
      test_backpressure();
      set_frame(200);
      test_random_streams();
      drain();
      repeat (20) @(posedge clock);
      if (fail_count == 0 && decoded_words.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   initial begin
      #2ms;
      $display("status: fail");
      $finish;
   end

endmodule
